/* design/mlfq_pkg.sv */
`default_nettype none
package mlfq_pkg;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_WAKE     = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_DISPATCH = 3'd3,
    OP_RUN_END  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_WRONG = 2'd2,
    ST_IDLE  = 2'd3
  } status_t;

  localparam int unsigned LEVELS = 4;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned QUANTUM_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;

  // Per-slot record: level minus one, ticks, in use, runnable, queued.
  typedef struct packed {
    logic [1:0]        level;
    logic [TICK_W-1:0] ticks;
    logic              in_use;
    logic              runnable;
    logic              queued;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

  // Reset value of a slot record: level one, zero ticks, free.
  localparam slot_rec_t REC_RESET = '{level: 2'd0, ticks: '0, in_use: 1'b0,
                                      runnable: 1'b0, queued: 1'b0};

endpackage
`default_nettype wire

/* design/mlfq_ram.sv */
`default_nettype none
module mlfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/four_level_feedback_queue_scheduler.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall  | in_operation, in_process_slot, in_exited
// out     | output    | out_valid / out_stall| out_status, out_chosen_slot,
//         |           |                      | out_chosen_level, out_demoted
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item at a time. Create, wake and block load their result in S_SOP; run_end,
// when a slot runs, loads it in S_RWT after S_RRD. A dispatch passes S_QRD for each
// empty level it checks, then reads the head entry (ring read from S_QRD, then slot
// record read from S_QWT, checked in S_HCHK); each stale entry dropped goes back to S_QRD.
// After reset a clearing pass writes SLOTS records, one a cycle; no item is
// taken until it ends. The input stalls while an item is in flight or a result waits.
`default_nettype none
module four_level_feedback_queue_scheduler #(
  parameter int unsigned SLOTS = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [2:0]  in_operation,
  input  wire [5:0]  in_process_slot,
  input  wire        in_exited,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_status,
  output logic [5:0] out_chosen_slot,
  output logic [2:0] out_chosen_level,
  output logic       out_demoted,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [7:0]  cfg_data
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned QW = SW + 2;
  localparam int unsigned TICK_W_L = mlfq_pkg::TICK_W;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SRD   = 10'b0000000100,
    S_SOP   = 10'b0000001000,
    S_QRD   = 10'b0000010000,
    S_QWT   = 10'b0000100000,
    S_HRD   = 10'b0001000000,
    S_HCHK  = 10'b0010000000,
    S_RRD   = 10'b0100000000,
    S_RWT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    quantum_r [4];
  logic [SW-1:0] head_r [4];
  logic [CW-1:0] count_r [4];
  logic [SW-1:0] run_slot_r;
  logic          run_valid_r;
  logic [SW-1:0] clr_r;

  logic [2:0] op_r;
  logic [5:0] slot_in_r;
  logic       exited_r;
  logic [1:0] lv_r;

  // Slot record memory.
  logic                      rec_we;
  logic [SW-1:0]             rec_waddr, rec_raddr;
  mlfq_pkg::slot_rec_t       rec_wdata;
  logic [mlfq_pkg::REC_W-1:0] rec_rdata_raw;
  mlfq_pkg::slot_rec_t       rec_rd;

  // Ring memory: level in top bits, position below.
  logic          q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  logic [SW-1:0] q_wdata, q_rdata;

  mlfq_ram #(.WIDTH(mlfq_pkg::REC_W), .DEPTH(SLOTS)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata_raw)
  );

  mlfq_ram #(.WIDTH(SW), .DEPTH(4 * (1 << SW))) u_ring (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign rec_rd = mlfq_pkg::slot_rec_t'(rec_rdata_raw);

  logic out_load;
  logic [1:0] o_st;
  logic [5:0] o_slot;
  logic [2:0] o_lv;
  logic       o_dem;

  logic [SW-1:0] head_nxt [4];
  logic [CW-1:0] count_nxt [4];
  logic [SW-1:0] run_slot_nxt;
  logic          run_valid_nxt;
  logic [1:0]    lv_nxt;

  logic [SW-1:0] cur_slot;
  logic          slot_ok;
  logic [SW:0]   tail_sum;
  logic [SW-1:0] tail_pos;
  logic [1:0]    push_lv;
  logic [SW:0]   head_inc;
  logic [TICK_W_L-1:0] ticks_inc;
  logic          at_head;
  logic [1:0]    next_lv;

  assign in_stall = (state_r != S_IDLE) || out_valid;
  assign cur_slot = run_slot_r;
  assign slot_ok = ({3'b000, slot_in_r} < 9'(SLOTS));

  always_comb begin
    tail_sum = {1'b0, head_r[push_lv]} + (SW + 1)'(count_r[push_lv]);
    if (tail_sum >= (SW + 1)'(SLOTS)) begin
      tail_pos = SW'(tail_sum - (SW + 1)'(SLOTS));
    end else begin
      tail_pos = tail_sum[SW-1:0];
    end
    head_inc = {1'b0, head_r[lv_r]} + (SW + 1)'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    rec_we        = 1'b0;
    rec_waddr     = SW'(slot_in_r);
    rec_wdata     = rec_rd;
    rec_raddr     = SW'(slot_in_r);
    q_we          = 1'b0;
    q_waddr       = '0;
    q_wdata       = '0;
    q_raddr       = {lv_r, head_r[lv_r]};
    push_lv       = lv_r;
    out_load      = 1'b0;
    o_st          = mlfq_pkg::ST_OK;
    o_slot        = '0;
    o_lv          = '0;
    o_dem         = 1'b0;
    run_slot_nxt  = run_slot_r;
    run_valid_nxt = run_valid_r;
    lv_nxt        = lv_r;
    at_head       = 1'b0;
    next_lv       = lv_r;
    ticks_inc     = rec_rd.ticks;
    for (int i = 0; i < 4; i++) begin
      head_nxt[i]  = head_r[i];
      count_nxt[i] = count_r[i];
    end

    case (state_r)
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_waddr = clr_r;
        rec_wdata = mlfq_pkg::REC_RESET;
        if (clr_r == SW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        // Choose which record to fetch for the operation.
        lv_nxt = 2'd0;
        case (op_r)
          mlfq_pkg::OP_DISPATCH, mlfq_pkg::OP_RUN_END: begin
            rec_raddr = cur_slot;
            state_nxt = S_SOP;
          end
          mlfq_pkg::OP_CREATE, mlfq_pkg::OP_WAKE, mlfq_pkg::OP_BLOCK: begin
            state_nxt = S_SOP;
          end
          default: begin
            out_load  = 1'b1;
            o_st      = mlfq_pkg::ST_WRONG;
            state_nxt = S_IDLE;
          end
        endcase
        if ((op_r == mlfq_pkg::OP_CREATE || op_r == mlfq_pkg::OP_WAKE ||
             op_r == mlfq_pkg::OP_BLOCK) && !slot_ok) begin
          out_load  = 1'b1;
          o_st      = mlfq_pkg::ST_WRONG;
          state_nxt = S_IDLE;
        end
      end
      S_SOP: begin
        state_nxt = S_IDLE;
        case (op_r)
          mlfq_pkg::OP_CREATE: begin
            out_load = 1'b1;
            if (rec_rd.in_use) begin
              o_st   = mlfq_pkg::ST_WRONG;
              o_slot = slot_in_r;
              o_lv   = {1'b0, rec_rd.level} + 3'd1;
            end else begin
              rec_we    = 1'b1;
              rec_wdata = '{level: 2'd0, ticks: '0, in_use: 1'b1,
                            runnable: 1'b1, queued: 1'b1};
              push_lv   = 2'd0;
              if (count_r[0] < CW'(SLOTS)) begin
                q_we        = 1'b1;
                q_waddr     = {2'd0, tail_pos};
                q_wdata     = SW'(slot_in_r);
                count_nxt[0] = count_r[0] + CW'(1);
              end
              o_slot = slot_in_r;
              o_lv   = 3'd1;
            end
          end
          mlfq_pkg::OP_WAKE, mlfq_pkg::OP_BLOCK: begin
            out_load = 1'b1;
            o_slot   = slot_in_r;
            o_lv     = {1'b0, rec_rd.level} + 3'd1;
            if (!rec_rd.in_use) begin
              o_st = mlfq_pkg::ST_WRONG;
            end else if (op_r == mlfq_pkg::OP_WAKE) begin
              rec_we = 1'b1;
              rec_wdata.runnable = 1'b1;
              if (!rec_rd.queued) begin
                rec_wdata.queued = 1'b1;
                push_lv = rec_rd.level;
                if (count_r[rec_rd.level] < CW'(SLOTS)) begin
                  q_we    = 1'b1;
                  q_waddr = {rec_rd.level, tail_pos};
                  q_wdata = SW'(slot_in_r);
                  count_nxt[rec_rd.level] = count_r[rec_rd.level] + CW'(1);
                end
              end
            end else begin
              rec_we = 1'b1;
              rec_wdata.runnable = 1'b0;
            end
          end
          mlfq_pkg::OP_DISPATCH: begin
            if (run_valid_r) begin
              out_load = 1'b1;
              o_st     = mlfq_pkg::ST_WRONG;
              o_slot   = 6'(cur_slot);
              o_lv     = {1'b0, rec_rd.level} + 3'd1;
            end else begin
              state_nxt = S_QRD;
            end
          end
          default: begin
            // Run end.
            if (!run_valid_r) begin
              out_load = 1'b1;
              o_st     = mlfq_pkg::ST_IDLE;
            end else begin
              lv_nxt    = rec_rd.level;
              state_nxt = S_RRD;
            end
          end
        endcase
      end
      S_QRD: begin
        // Find a non-empty level, then read its head entry.
        if (count_r[lv_r] != '0) begin
          state_nxt = S_QWT;
        end else if (lv_r == 2'd3) begin
          out_load  = 1'b1;
          o_st      = mlfq_pkg::ST_NONE;
          state_nxt = S_IDLE;
        end else begin
          lv_nxt = lv_r + 2'd1;
        end
      end
      S_QWT: begin
        rec_raddr = q_rdata;
        state_nxt = S_HCHK;
      end
      S_HRD: begin
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (rec_rd.in_use && rec_rd.runnable) begin
          out_load      = 1'b1;
          o_slot        = 6'(q_rdata);
          o_lv          = {1'b0, lv_r} + 3'd1;
          run_slot_nxt  = q_rdata;
          run_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // Drop the stale head entry and look again.
          rec_we    = 1'b1;
          rec_waddr = q_rdata;
          rec_wdata.queued = 1'b0;
          head_nxt[lv_r] = (head_inc >= (SW + 1)'(SLOTS)) ? '0 : head_inc[SW-1:0];
          count_nxt[lv_r] = count_r[lv_r] - CW'(1);
          state_nxt = S_QRD;
        end
      end
      S_RRD: begin
        // Ring head of the running slot's level is being read.
        rec_raddr = cur_slot;
        state_nxt = S_RWT;
      end
      default: begin
        // S_RWT: record and ring head both valid.
        state_nxt     = S_IDLE;
        out_load      = 1'b1;
        run_valid_nxt = 1'b0;
        rec_we        = 1'b1;
        rec_waddr     = cur_slot;
        o_slot        = 6'(cur_slot);
        ticks_inc = (rec_rd.ticks != mlfq_pkg::TICK_MAX) ?
                    rec_rd.ticks + TICK_W_L'(1) : rec_rd.ticks;
        at_head = rec_rd.queued && (count_r[lv_r] != '0) && (q_rdata == cur_slot);
        next_lv = (lv_r == 2'd3) ? 2'd3 : lv_r + 2'd1;
        push_lv = next_lv;
        rec_wdata.ticks = ticks_inc;
        o_lv = {1'b0, lv_r} + 3'd1;
        if (exited_r) begin
          if (at_head) begin
            head_nxt[lv_r] = (head_inc >= (SW + 1)'(SLOTS)) ? '0 : head_inc[SW-1:0];
            count_nxt[lv_r] = count_r[lv_r] - CW'(1);
          end
          rec_wdata.queued   = 1'b0;
          rec_wdata.in_use   = 1'b0;
          rec_wdata.runnable = 1'b0;
          rec_wdata.ticks    = '0;
        end else if (ticks_inc >= quantum_r[lv_r]) begin
          o_dem = 1'b1;
          o_lv  = {1'b0, next_lv} + 3'd1;
          rec_wdata.level  = next_lv;
          rec_wdata.ticks  = '0;
          rec_wdata.queued = 1'b1;
          begin
            // Pop and push may hit the same level (level 4 rotation).
            logic [CW-1:0] cnt_after;
            logic [SW-1:0] hd_after;
            logic [SW:0]   ts;
            cnt_after = count_r[next_lv];
            hd_after  = head_r[next_lv];
            if (at_head) begin
              head_nxt[lv_r] = (head_inc >= (SW + 1)'(SLOTS)) ? '0 : head_inc[SW-1:0];
              count_nxt[lv_r] = count_r[lv_r] - CW'(1);
              if (next_lv == lv_r) begin
                cnt_after = count_nxt[lv_r];
                hd_after  = head_nxt[lv_r];
              end
            end
            ts = {1'b0, hd_after} + (SW + 1)'(cnt_after);
            if (cnt_after < CW'(SLOTS)) begin
              q_we    = 1'b1;
              q_waddr = {next_lv, (ts >= (SW + 1)'(SLOTS)) ?
                         SW'(ts - (SW + 1)'(SLOTS)) : ts[SW-1:0]};
              q_wdata = cur_slot;
              count_nxt[next_lv] = cnt_after + CW'(1);
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      out_valid   <= 1'b0;
      lv_r        <= '0;
      quantum_r[0] <= 8'd1;
      quantum_r[1] <= 8'd3;
      quantum_r[2] <= 8'd9;
      quantum_r[3] <= 8'd15;
      for (int i = 0; i < 4; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_r + SW'(1);
      run_valid_r <= run_valid_nxt;
      run_slot_r  <= run_slot_nxt;
      lv_r        <= lv_nxt;
      for (int i = 0; i < 4; i++) begin
        head_r[i]  <= head_nxt[i];
        count_r[i] <= count_nxt[i];
      end
      if (cfg_we) begin
        quantum_r[cfg_index] <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      op_r      <= in_operation;
      slot_in_r <= in_process_slot;
      exited_r  <= in_exited;
    end
    if (out_load) begin
      out_status       <= o_st;
      out_chosen_slot  <= o_slot;
      out_chosen_level <= o_lv;
      out_demoted      <= o_dem;
    end
  end

endmodule
`default_nettype wire
